[src/lcd_seq_pkg.sv]
// Package: shared types, codes and constants of the LCD expander sequencer.
package lcd_seq_pkg;

  // Request action codes
  typedef enum logic [2:0] {
    ACT_COMMAND  = 3'd0,
    ACT_DATA     = 3'd1,
    ACT_CONTROL  = 3'd2,
    ACT_CURSOR   = 3'd3,
    ACT_CLEAR    = 3'd4,
    ACT_INIT     = 3'd5,
    ACT_SHUTDOWN = 3'd6,
    ACT_UNUSED   = 3'd7
  } action_t;

  // Result kind codes
  typedef enum logic [1:0] {
    KIND_WRITE  = 2'd0,
    KIND_WAIT   = 2'd1,
    KIND_REJECT = 2'd2
  } kind_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_DEVICE_ADDRESS = 2'd0;
  localparam logic [1:0] CFG_PULSE_WAIT     = 2'd1;
  localparam logic [1:0] CFG_COMMAND_WAIT   = 2'd2;
  localparam logic [1:0] CFG_POWER_UP_WAIT  = 2'd3;

  // Configuration reset values
  localparam logic [6:0] RST_DEVICE_ADDRESS = 7'h27;
  localparam logic [7:0] RST_PULSE_WAIT     = 8'd5;
  localparam logic [7:0] RST_COMMAND_WAIT   = 8'd41;
  localparam logic [9:0] RST_POWER_UP_WAIT  = 10'd200;

  // Expander byte flag bits
  localparam logic [7:0] BIT_BACKLIGHT = 8'h08;
  localparam logic [7:0] BIT_ENABLE    = 8'h04;
  localparam logic [7:0] BIT_RS        = 8'h01;

  // Fixed LCD commands
  localparam logic [7:0] CMD_CLEAR      = 8'h01;
  localparam logic [7:0] CMD_DISP_BASE  = 8'h0C;
  localparam logic [7:0] CMD_DISP_OFF   = 8'h08;
  localparam logic [7:0] CMD_ROW0_BASE  = 8'h80;
  localparam logic [7:0] CMD_ROW1_BASE  = 8'hC0;
  localparam logic [7:0] MAX_COLUMN     = 8'd15;
  localparam logic [7:0] MAX_ROW        = 8'd1;

  // Sequencing limits: six writes per byte, six bytes in the init run
  localparam logic [2:0] LAST_STEP      = 3'd5;
  localparam logic [2:0] LAST_INIT_IDX  = 3'd5;

  // Request class seen by the controller
  typedef enum logic [1:0] {
    RC_REJECT = 2'd0,
    RC_INIT   = 2'd1,
    RC_BYTE   = 2'd2
  } req_class_t;

  // Input transaction payload
  typedef struct packed {
    logic [2:0] action;
    logic [7:0] value;
    logic [7:0] column;
    logic [7:0] row;
    logic       backlight_on;
    logic       cursor_on;
    logic       blink_on;
  } req_t;

  // Result transaction payload
  typedef struct packed {
    kind_t      kind;
    logic [6:0] bus_address;
    logic [7:0] expander_byte;
    logic [9:0] wait_units;
    logic       last;
  } item_t;

  // Controller to datapath command
  typedef struct packed {
    logic       load;
    logic       emit;
    kind_t      kind;
    logic [2:0] step;
    logic       use_init;
    logic [2:0] init_idx;
    logic       last;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    req_class_t req_class;
    logic       out_free;
  } stat_t;

  // Init command run
  function automatic logic [7:0] init_cmd(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h02;
      3'd1:    c = 8'h28;
      3'd2:    c = 8'h0C;
      3'd3:    c = 8'h06;
      3'd4:    c = 8'h80;
      default: c = 8'h01;
    endcase
    return c;
  endfunction

endpackage

[src/lcd_seq_in_if.sv]
// Interface: request channel of the LCD expander sequencer.
interface lcd_seq_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [7:0] value;
  logic [7:0] column;
  logic [7:0] row;
  logic       backlight_on;
  logic       cursor_on;
  logic       blink_on;

  modport source (output valid, action, value, column, row, backlight_on, cursor_on,
                  blink_on, input ready);
  modport sink   (input valid, action, value, column, row, backlight_on, cursor_on,
                  blink_on, output ready);
endinterface

[src/lcd_seq_out_if.sv]
// Interface: result channel of the LCD expander sequencer.
interface lcd_seq_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [6:0] bus_address;
  logic [7:0] expander_byte;
  logic [9:0] wait_units;
  logic       last;

  modport source (output valid, kind, bus_address, expander_byte, wait_units, last,
                  input ready);
  modport sink   (input valid, kind, bus_address, expander_byte, wait_units, last,
                  output ready);
endinterface

[src/lcd_seq_cfg_if.sv]
// Interface: configuration write channel of the LCD expander sequencer.
interface lcd_seq_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [9:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[src/lcd_seq_ctrl.sv]
// Controller: state machine that steps through the writes of each request.
module lcd_seq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  lcd_seq_pkg::stat_t stat,
  output logic               in_ready,
  output lcd_seq_pkg::cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_REJ  = 4'b0010,
    S_WAIT = 4'b0100,
    S_BYTE = 4'b1000
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] step_r, step_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic       init_r, init_nxt;

  // Next state and command
  always_comb begin
    state_nxt    = state_r;
    step_nxt     = step_r;
    idx_nxt      = idx_r;
    init_nxt     = init_r;
    in_ready     = 1'b0;
    cmd.load     = 1'b0;
    cmd.emit     = 1'b0;
    cmd.kind     = lcd_seq_pkg::KIND_WRITE;
    cmd.step     = step_r;
    cmd.use_init = init_r;
    cmd.init_idx = idx_r;
    cmd.last     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          step_nxt = 3'd0;
          idx_nxt  = 3'd0;
          init_nxt = (stat.req_class == lcd_seq_pkg::RC_INIT);
          case (stat.req_class)
            lcd_seq_pkg::RC_REJECT: state_nxt = S_REJ;
            lcd_seq_pkg::RC_INIT:   state_nxt = S_WAIT;
            default:                state_nxt = S_BYTE;
          endcase
        end
      end
      S_REJ: begin
        cmd.kind = lcd_seq_pkg::KIND_REJECT;
        cmd.last = 1'b1;
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_WAIT: begin
        cmd.kind = lcd_seq_pkg::KIND_WAIT;
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_BYTE;
        end
      end
      S_BYTE: begin
        cmd.kind = lcd_seq_pkg::KIND_WRITE;
        cmd.last = (step_r == lcd_seq_pkg::LAST_STEP) &&
                   (!init_r || idx_r == lcd_seq_pkg::LAST_INIT_IDX);
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (step_r == lcd_seq_pkg::LAST_STEP) begin
            step_nxt = 3'd0;
            if (cmd.last) begin
              state_nxt = S_IDLE;
            end else begin
              idx_nxt = idx_r + 3'd1;
            end
          end else begin
            step_nxt = step_r + 3'd1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= 3'd0;
      idx_r   <= 3'd0;
      init_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      idx_r   <= idx_nxt;
      init_r  <= init_nxt;
    end
  end

endmodule

[src/lcd_seq_dp.sv]
// Datapath: configuration, request latch, byte builder and output register.
module lcd_seq_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  lcd_seq_pkg::req_t  req,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [9:0]         cfg_data,
  input  lcd_seq_pkg::cmd_t  cmd,
  input  logic               out_ready,
  output lcd_seq_pkg::stat_t stat,
  output logic               out_valid,
  output lcd_seq_pkg::item_t out_item
);

  logic [6:0] dev_addr_r;
  logic [7:0] pulse_wait_r;
  logic [7:0] command_wait_r;
  logic [9:0] power_up_wait_r;
  logic       backlight_r, backlight_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic       data_r;
  logic       out_valid_r;
  lcd_seq_pkg::item_t item_r, item_nxt;
  lcd_seq_pkg::req_class_t req_class;
  logic [7:0] cur_byte;
  logic [3:0] nibble;
  logic [7:0] wr_byte;
  logic [9:0] wr_wait;
  logic       cursor_ok;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r      <= lcd_seq_pkg::RST_DEVICE_ADDRESS;
      pulse_wait_r    <= lcd_seq_pkg::RST_PULSE_WAIT;
      command_wait_r  <= lcd_seq_pkg::RST_COMMAND_WAIT;
      power_up_wait_r <= lcd_seq_pkg::RST_POWER_UP_WAIT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lcd_seq_pkg::CFG_DEVICE_ADDRESS: dev_addr_r      <= cfg_data[6:0];
        lcd_seq_pkg::CFG_PULSE_WAIT:     pulse_wait_r    <= cfg_data[7:0];
        lcd_seq_pkg::CFG_COMMAND_WAIT:   command_wait_r  <= cfg_data[7:0];
        lcd_seq_pkg::CFG_POWER_UP_WAIT:  power_up_wait_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Request decode: class, byte to send, backlight update
  assign cursor_ok = (req.column <= lcd_seq_pkg::MAX_COLUMN) &&
                     (req.row <= lcd_seq_pkg::MAX_ROW);

  always_comb begin
    req_class     = lcd_seq_pkg::RC_BYTE;
    byte_nxt      = req.value;
    backlight_nxt = backlight_r;
    unique case (lcd_seq_pkg::action_t'(req.action)) inside
      lcd_seq_pkg::ACT_COMMAND, lcd_seq_pkg::ACT_DATA: byte_nxt = req.value;
      lcd_seq_pkg::ACT_CONTROL: begin
        byte_nxt      = lcd_seq_pkg::CMD_DISP_BASE | {6'd0, req.cursor_on, req.blink_on};
        backlight_nxt = req.backlight_on;
      end
      lcd_seq_pkg::ACT_CURSOR: begin
        byte_nxt = ((req.row == 8'd0) ? lcd_seq_pkg::CMD_ROW0_BASE
                                      : lcd_seq_pkg::CMD_ROW1_BASE) | req.column;
        if (!cursor_ok) req_class = lcd_seq_pkg::RC_REJECT;
      end
      lcd_seq_pkg::ACT_CLEAR: byte_nxt = lcd_seq_pkg::CMD_CLEAR;
      lcd_seq_pkg::ACT_INIT: begin
        req_class     = lcd_seq_pkg::RC_INIT;
        backlight_nxt = 1'b1;
      end
      lcd_seq_pkg::ACT_SHUTDOWN: begin
        byte_nxt      = lcd_seq_pkg::CMD_DISP_OFF;
        backlight_nxt = 1'b0;
      end
      default: req_class = lcd_seq_pkg::RC_REJECT;
    endcase
  end

  assign stat.req_class = req_class;

  // Backlight state; a rejected request leaves it alone
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      backlight_r <= 1'b1;
    end else if (cmd.load && req_class != lcd_seq_pkg::RC_REJECT) begin
      backlight_r <= backlight_nxt;
    end
  end

  // Request latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      byte_r <= byte_nxt;
      data_r <= (req.action == lcd_seq_pkg::ACT_DATA);
    end
  end

  // Expander byte for the current step: high nibble in steps 0-2, low in 3-5
  assign cur_byte = cmd.use_init ? lcd_seq_pkg::init_cmd(cmd.init_idx) : byte_r;
  assign nibble   = (cmd.step < 3'd3) ? cur_byte[7:4] : cur_byte[3:0];
  assign wr_byte  = {nibble, 4'd0}
                  | (backlight_r ? lcd_seq_pkg::BIT_BACKLIGHT : 8'd0)
                  | ((cmd.step == 3'd1 || cmd.step == 3'd4) ? lcd_seq_pkg::BIT_ENABLE : 8'd0)
                  | ((data_r && !cmd.use_init) ? lcd_seq_pkg::BIT_RS : 8'd0);

  // Wait after the write: long wait closes a command nibble and every low nibble
  always_comb begin
    if (cmd.step == lcd_seq_pkg::LAST_STEP ||
        (cmd.step == 3'd2 && !(data_r && !cmd.use_init))) begin
      wr_wait = {2'd0, command_wait_r};
    end else begin
      wr_wait = {2'd0, pulse_wait_r};
    end
  end

  // Result assembly
  always_comb begin
    item_nxt.kind          = cmd.kind;
    item_nxt.bus_address   = 7'd0;
    item_nxt.expander_byte = 8'd0;
    item_nxt.wait_units    = 10'd0;
    item_nxt.last          = cmd.last;
    case (cmd.kind)
      lcd_seq_pkg::KIND_WRITE: begin
        item_nxt.bus_address   = dev_addr_r;
        item_nxt.expander_byte = wr_byte;
        item_nxt.wait_units    = wr_wait;
      end
      lcd_seq_pkg::KIND_WAIT: item_nxt.wait_units = power_up_wait_r;
      default: ;
    endcase
  end

  // Output register
  assign stat.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      item_r <= item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = item_r;

endmodule

[src/char_lcd_i2c_expander_sequencer.sv]
// Top level: character LCD request to I2C expander write sequencer.
//
//  channel | dir | handshake     | payload
//  in_if   | in  | valid/ready   | action, value, column, row, backlight_on, cursor_on, blink_on
//  out_if  | out | valid/ready   | kind, bus_address, expander_byte, wait_units, last
//  cfg_if  | in  | valid/ready   | index, data (always ready)
//
// One request at a time: once a request is accepted, one result per cycle while the
// result register drains; a byte request yields its writes, init a power-up wait and its
// run of writes, a reject a single rejection. The controller's step and byte counters set each length.
// Synchronous active-low reset restores register defaults and backlight on.
// A stalled result holds the sequence; the next request is taken once the last
// result has been registered.
module char_lcd_i2c_expander_sequencer (
  input  logic    clk,
  input  logic    rst_n,
  lcd_seq_in_if.sink    in_if,
  lcd_seq_out_if.source out_if,
  lcd_seq_cfg_if.sink   cfg_if
);

  lcd_seq_pkg::req_t  req;
  lcd_seq_pkg::cmd_t  cmd;
  lcd_seq_pkg::stat_t stat;
  lcd_seq_pkg::item_t item;
  logic               out_valid;
  logic               in_ready;

  // Pack request payload
  assign req.action       = in_if.action;
  assign req.value        = in_if.value;
  assign req.column       = in_if.column;
  assign req.row          = in_if.row;
  assign req.backlight_on = in_if.backlight_on;
  assign req.cursor_on    = in_if.cursor_on;
  assign req.blink_on     = in_if.blink_on;
  assign in_if.ready      = in_ready;
  assign cfg_if.ready     = 1'b1;

  lcd_seq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .stat     (stat),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  lcd_seq_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req),
    .cfg_we    (cfg_if.valid),
    .cfg_index (cfg_if.index),
    .cfg_data  (cfg_if.data),
    .cmd       (cmd),
    .out_ready (out_if.ready),
    .stat      (stat),
    .out_valid (out_valid),
    .out_item  (item)
  );

  // Unpack result payload
  assign out_if.valid         = out_valid;
  assign out_if.kind          = item.kind;
  assign out_if.bus_address   = item.bus_address;
  assign out_if.expander_byte = item.expander_byte;
  assign out_if.wait_units    = item.wait_units;
  assign out_if.last          = item.last;

  // A request is never taken in the cycle after another was taken
  a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready) |=> !in_if.ready)
    else $error("request accepted in two consecutive cycles");

  // A rejection is always the single, final result
  a_reject_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.kind == lcd_seq_pkg::KIND_REJECT) |->
      (out_if.last && out_if.wait_units == 10'd0 && out_if.expander_byte == 8'd0))
    else $error("rejection result malformed");

  // A power-up wait is never the last result and carries no write
  a_wait_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.kind == lcd_seq_pkg::KIND_WAIT) |->
      (!out_if.last && out_if.bus_address == 7'd0 && out_if.expander_byte == 8'd0))
    else $error("wait result malformed");

  // A new request is only taken once the previous sequence has emitted its last result
  a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready && out_if.valid) |-> out_if.last)
    else $error("request accepted while a previous sequence is unfinished");

endmodule
